[src/hsv2rgb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

    // default channel width for saturation, value and the RGB outputs
    localparam int CHANNEL_BITS_DEF = 8;

    localparam int HUE_BITS    = 11;
    localparam int FRAC_BITS   = 8;
    localparam int SECTOR_BITS = 3;

    localparam logic [SECTOR_BITS-1:0] SECT_RED_YEL   = 3'd0;
    localparam logic [SECTOR_BITS-1:0] SECT_YEL_GRN   = 3'd1;
    localparam logic [SECTOR_BITS-1:0] SECT_GRN_CYN   = 3'd2;
    localparam logic [SECTOR_BITS-1:0] SECT_CYN_BLU   = 3'd3;
    localparam logic [SECTOR_BITS-1:0] SECT_BLU_MAG   = 3'd4;

    // shaded level lanes
    localparam int LANE_P  = 0;
    localparam int LANE_Q  = 1;
    localparam int LANE_T  = 2;
    localparam int N_LANES = 3;

endpackage

`default_nettype wire

[src/hsv2rgb_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface hsv2rgb_in_if #(
    parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic [hsv2rgb_pkg::HUE_BITS-1:0]    hue;
    logic [CHANNEL_BITS-1:0]             saturation;
    logic [CHANNEL_BITS-1:0]             brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_out_if #(
    parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

[src/hsv_to_rgb_converter.sv]
// HSV to RGB pixel converter, one pixel per clock while o_pix is not stalled.
// i_pix (sink) takes a word of hue (11 bits: sector in bits 10..8, fraction in
// 7..0), saturation and brightness; o_pix (source) gives red, green, blue.
// Both channels use valid/ready; a word moves when both are high.
// Throughput: one word per cycle while the receiver keeps o_pix.ready high. The
// four register stages are fraction products, value multiply, reciprocal
// estimate of the divide by 2^W-1 (W = CHANNEL_BITS), then correction and sector mux.
// Each stage has its own valid bit and holds while the stage after it is full
// and stalled, so a bubble is squeezed out and i_pix.ready only drops once the
// pipeline is full behind a stalled receiver. Nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline; the block keeps no
// other state. Saturation zero gives grey: all channels equal brightness.
// Sectors 6 and 7 map like sector 5.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter #(
    parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hsv2rgb_in_if.sink    i_pix,
    hsv2rgb_out_if.source o_pix
);
    import hsv2rgb_pkg::*;

    localparam int W  = CHANNEL_BITS;
    localparam int PW = W + FRAC_BITS;
    localparam int YW = 2 * W;

    localparam logic [W-1:0]  CMAX = {W{1'b1}};
    // (CMAX-1)/2 = 2^(W-1)-1
    localparam logic [YW-1:0] HALF = {{(W+1){1'b0}}, {(W-1){1'b1}}};

    // stage enables
    logic en1, en2, en3, en4;

    // stage 1: saturation times fraction
    logic                   r_v1;
    logic [PW-1:0]          r1_pf;
    logic [PW-1:0]          r1_pt;
    logic [W-1:0]           r1_s;
    logic [W-1:0]           r1_val;
    logic [SECTOR_BITS-1:0] r1_sect;
    logic                   r1_grey;

    // stage 2: value times level
    logic                   r_v2;
    logic [YW-1:0]          r2_prod [N_LANES];
    logic [W-1:0]           r2_val;
    logic [SECTOR_BITS-1:0] r2_sect;
    logic                   r2_grey;
    logic [W-1:0]           n_lvl   [N_LANES];

    // stage 3: rounded sum and quotient estimate
    logic                   r_v3;
    logic [YW-1:0]          r3_y    [N_LANES];
    logic [W:0]             r3_q    [N_LANES];
    logic [W-1:0]           r3_val;
    logic [SECTOR_BITS-1:0] r3_sect;
    logic                   r3_grey;
    logic [YW-1:0]          n_y     [N_LANES];
    logic [YW:0]            n_ysum  [N_LANES];

    // stage 4: corrected levels, sector mux
    logic                   r_v4;
    logic [W-1:0]           r4_red;
    logic [W-1:0]           r4_green;
    logic [W-1:0]           r4_blue;
    logic [YW:0]            n_rem   [N_LANES];
    logic [W-1:0]           n_sh    [N_LANES];
    logic [W-1:0]           n_red;
    logic [W-1:0]           n_green;
    logic [W-1:0]           n_blue;

    assign en4 = !r_v4 || o_pix.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_pix.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_pix.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_pf   <= PW'(i_pix.saturation) * PW'(i_pix.hue[FRAC_BITS-1:0]);
            r1_pt   <= PW'(i_pix.saturation)
                       * PW'(9'd256 - {1'b0, i_pix.hue[FRAC_BITS-1:0]});
            r1_s    <= i_pix.saturation;
            r1_val  <= i_pix.brightness;
            r1_sect <= i_pix.hue[HUE_BITS-1:FRAC_BITS];
            r1_grey <= (i_pix.saturation == '0);
        end
    end

    // stage 2: levels never go negative, the subtracted term is at most s
    assign n_lvl[LANE_P] = CMAX - r1_s;
    assign n_lvl[LANE_Q] = CMAX - r1_pf[PW-1:FRAC_BITS];
    assign n_lvl[LANE_T] = CMAX - r1_pt[PW-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int k = 0; k < N_LANES; k++) begin
                r2_prod[k] <= YW'(r1_val) * YW'(n_lvl[k]);
            end
            r2_val  <= r1_val;
            r2_sect <= r1_sect;
            r2_grey <= r1_grey;
        end
    end

    // stage 3: y/(2^W-1) ~ (y + y>>W) >> W, low by at most one
    always_comb begin
        for (int k = 0; k < N_LANES; k++) begin
            n_y[k]    = r2_prod[k] + HALF;
            n_ysum[k] = {1'b0, n_y[k]} + (YW + 1)'(n_y[k] >> W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            for (int k = 0; k < N_LANES; k++) begin
                r3_y[k] <= n_y[k];
                r3_q[k] <= n_ysum[k][YW:W];
            end
            r3_val  <= r2_val;
            r3_sect <= r2_sect;
            r3_grey <= r2_grey;
        end
    end

    // stage 4: remainder y - q*CMAX, bump q if it reaches CMAX
    always_comb begin
        for (int k = 0; k < N_LANES; k++) begin
            n_rem[k] = {1'b0, r3_y[k]} + (YW + 1)'(r3_q[k])
                       - {1'b0, r3_q[k][W-1:0], {W{1'b0}}};
            n_sh[k]  = (n_rem[k] >= (YW + 1)'(CMAX)) ? r3_q[k][W-1:0] + 1'b1
                                                      : r3_q[k][W-1:0];
        end

        case (r3_sect)
            SECT_RED_YEL: begin
                n_red = r3_val;         n_green = n_sh[LANE_T]; n_blue = n_sh[LANE_P];
            end
            SECT_YEL_GRN: begin
                n_red = n_sh[LANE_Q];   n_green = r3_val;       n_blue = n_sh[LANE_P];
            end
            SECT_GRN_CYN: begin
                n_red = n_sh[LANE_P];   n_green = r3_val;       n_blue = n_sh[LANE_T];
            end
            SECT_CYN_BLU: begin
                n_red = n_sh[LANE_P];   n_green = n_sh[LANE_Q]; n_blue = r3_val;
            end
            SECT_BLU_MAG: begin
                n_red = n_sh[LANE_T];   n_green = n_sh[LANE_P]; n_blue = r3_val;
            end
            default: begin
                n_red = r3_val;         n_green = n_sh[LANE_P]; n_blue = n_sh[LANE_Q];
            end
        endcase

        if (r3_grey) begin
            n_red   = r3_val;
            n_green = r3_val;
            n_blue  = r3_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_red   <= n_red;
            r4_green <= n_green;
            r4_blue  <= n_blue;
        end
    end

    assign o_pix.valid = r_v4;
    assign o_pix.red   = r4_red;
    assign o_pix.green = r4_green;
    assign o_pix.blue  = r4_blue;

endmodule

`default_nettype wire

[tb/sv/hsv_to_rgb_converter_test.sv]
`timescale 1ns / 1ps

module hsv_to_rgb_converter_test;
    import hsv2rgb_pkg::*;

    localparam int CB = CHANNEL_BITS_DEF;
    localparam longint unsigned CMAX = (64'd1 << CB) - 1;
    localparam int RAND_PIXELS = 1700;
    localparam int N_PHASES = 4;
    localparam int TAIL_CYCLES = 12;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
    } t_rgb;

    class pixel_scoreboard;
        t_rgb expected_px[$];
        int   failures;

        function new();
            failures = 0;
        endfunction

        function longint unsigned scale_level(longint unsigned v, longint unsigned level);
            return (v * level + (CMAX - 1) / 2) / CMAX;
        endfunction

        function t_rgb hsv_to_rgb(logic [HUE_BITS-1:0] hue, logic [CB-1:0] sat,
                                  logic [CB-1:0] val);
            logic [SECTOR_BITS-1:0] sector;
            longint unsigned frac, s, v, p, q, t;
            t_rgb px;
            sector = hue[HUE_BITS-1 -: SECTOR_BITS];
            frac = 64'(hue[FRAC_BITS-1:0]);
            s = 64'(sat);
            v = 64'(val);
            if (s == 0) begin
                px = {val, val, val};
                return px;
            end
            p = scale_level(v, CMAX - s);
            q = scale_level(v, CMAX - ((s * frac) >> 8));
            t = scale_level(v, CMAX - ((s * (64'd256 - frac)) >> 8));
            // sectors past five fall into the default mapping
            case (sector)
                SECT_RED_YEL: px = {v[CB-1:0], t[CB-1:0], p[CB-1:0]};
                SECT_YEL_GRN: px = {q[CB-1:0], v[CB-1:0], p[CB-1:0]};
                SECT_GRN_CYN: px = {p[CB-1:0], v[CB-1:0], t[CB-1:0]};
                SECT_CYN_BLU: px = {p[CB-1:0], q[CB-1:0], v[CB-1:0]};
                SECT_BLU_MAG: px = {t[CB-1:0], p[CB-1:0], v[CB-1:0]};
                default:      px = {v[CB-1:0], p[CB-1:0], q[CB-1:0]};
            endcase
            return px;
        endfunction

        function void note_pixel(logic [HUE_BITS-1:0] hue, logic [CB-1:0] sat,
                                 logic [CB-1:0] val);
            expected_px.push_back(hsv_to_rgb(hue, sat, val));
        endfunction

        function void check_pixel(t_rgb got);
            t_rgb want;
            if (expected_px.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected word r=%0d g=%0d b=%0d",
                             $realtime, got.red, got.green, got.blue);
                return;
            end
            want = expected_px.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                             $realtime, want.red, want.green, want.blue,
                             got.red, got.green, got.blue);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   src_quiet;
    bit   snk_quiet;
    pixel_scoreboard books;

    hsv2rgb_in_if  #(.CHANNEL_BITS(CB)) pix_in ();
    hsv2rgb_out_if #(.CHANNEL_BITS(CB)) pix_out ();

    hsv_to_rgb_converter #(.CHANNEL_BITS(CB)) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_in.sink),
        .o_pix   (pix_out.source)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CB-1:0] rand_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CMAX[CB-1:0];
            2: return CB'(1);
            default: return CB'($urandom_range(0, 32'(CMAX)));
        endcase
    endfunction

    function automatic logic [HUE_BITS-1:0] rand_hue();
        if ($urandom_range(0, 7) == 0) return HUE_BITS'($urandom_range(1536, 2047));
        return HUE_BITS'($urandom_range(0, 1535));
    endfunction

    // valid is left high after acceptance; the next call or drain_pixels decides
    task automatic send_pixel(logic [HUE_BITS-1:0] hue, logic [CB-1:0] sat,
                              logic [CB-1:0] val);
        int gap;
        gap = pick_gap(src_quiet);
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.hue        <= hue;
        pix_in.saturation <= sat;
        pix_in.brightness <= val;
        @(posedge clk);
        while (!pix_in.ready) @(posedge clk);
    endtask

    task automatic drain_pixels();
        pix_in.valid <= 1'b0;
        // let the clock advance so the monitor has logged the last word
        @(posedge clk);
        while (books.expected_px.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (pix_in.valid && pix_in.ready)
                books.note_pixel(pix_in.hue, pix_in.saturation, pix_in.brightness);
            if (pix_out.valid && pix_out.ready)
                books.check_pixel({pix_out.red, pix_out.green, pix_out.blue});
        end
    end

    initial begin
        int hold;
        pix_out.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 29) == 0) snk_quiet = ~snk_quiet;
            hold = pick_gap(snk_quiet);
            if (hold > 0) begin
                pix_out.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            pix_out.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial begin
        logic [SECTOR_BITS-1:0] sec;
        books = new();
        rst_n             <= 1'b0;
        pix_in.valid      <= 1'b0;
        pix_in.hue        <= '0;
        pix_in.saturation <= '0;
        pix_in.brightness <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // grey pixels
        send_pixel(11'd700, '0, '1);
        send_pixel(11'd0, '0, '0);
        // every sector, including the two past range, at both fraction ends
        for (int i = 0; i < 8; i++) begin
            sec = i[SECTOR_BITS-1:0];
            send_pixel({sec, 8'h00}, '1, '1);
            send_pixel({sec, 8'hFF}, '1, '1);
        end
        send_pixel(11'd2047, CB'(1), CB'(1));
        send_pixel(11'd0, '1, '0);
        send_pixel(11'd1535, 8'd128, 8'd200);
        send_pixel(11'd1536, 8'd77, 8'd255);
        drain_pixels();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            src_quiet = (ph == 1);
            for (int n = 0; n < RAND_PIXELS / N_PHASES; n++)
                send_pixel(rand_hue(), rand_level(), rand_level());
            drain_pixels();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (books.failures == 0 && books.expected_px.size() == 0) begin
            $display("hsv_to_rgb_converter_test OK");
        end else begin
            $display("hsv_to_rgb_converter_test NOT OK");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("hsv_to_rgb_converter_test NOT OK");
        $finish;
    end

endmodule
